### hdl/mwia_pkg.sv
// ----------------------------------------------------------------------------
// mwia_pkg - shared types and codes for the multi-width integer ALU
// Operation codes, result kinds and the side data that rides the pipeline.
// ----------------------------------------------------------------------------
package mwia_pkg;

  localparam int DATA_W = 64;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_UDIV = 5'd3,
    OP_SDIV  = 5'd4,  OP_UREM = 5'd5,  OP_SREM = 5'd6,  OP_SHL  = 5'd7,
    OP_LSHR  = 5'd8,  OP_ASHR = 5'd9,  OP_AND  = 5'd10, OP_OR   = 5'd11,
    OP_XOR   = 5'd12, OP_SEXT = 5'd13, OP_ZEXT = 5'd14, OP_TRUNC = 5'd15,
    OP_EQ    = 5'd16, OP_NE   = 5'd17, OP_UGT  = 5'd18, OP_UGE  = 5'd19,
    OP_ULT   = 5'd20, OP_ULE  = 5'd21, OP_SGT  = 5'd22, OP_SGE  = 5'd23,
    OP_SLE   = 5'd24, OP_SLT  = 5'd25, OP_SELECT = 5'd26
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_OVFL  = 2'd2,
    ERR_SHIFT = 2'd3
  } err_t;

  // where the final value comes from
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_QUO    = 2'd2,
    KIND_REM    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [6:0]        w;      // result width in bits
    err_t              err;
    kind_t             kind;
    logic              neg;    // negate divider result
    logic [DATA_W-1:0] res;    // result of the ops computed at decode
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [DATA_W-1:0] a;      // masked operands for the multiplier
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] num;    // divider dividend / divisor magnitudes
    logic [DATA_W-1:0] den;
  } prep_t;

  function automatic logic [6:0] width_of(input logic [2:0] cls);
    logic [6:0] w;
    case (cls)
      3'd0:    w = 7'd1;
      3'd1:    w = 7'd8;
      3'd2:    w = 7'd16;
      3'd3:    w = 7'd32;
      default: w = 7'd64;
    endcase
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] mask_of(input logic [6:0] w);
    return ~({DATA_W{1'b1}} << w);
  endfunction

endpackage

### hdl/mwia_prep.sv
// ----------------------------------------------------------------------------
// mwia_prep - operand decode and combinational operations
// Masks operands to width, flags errors, computes all ops but mul and divide,
// and sets up magnitudes for the divider.
// ----------------------------------------------------------------------------
module mwia_prep import mwia_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [4:0]        mode,
  input  logic [2:0]        width_class,
  input  logic [2:0]        source_class,
  input  logic [6:0]        source_bits,
  input  logic [DATA_W-1:0] operand_a,
  input  logic [DATA_W-1:0] operand_b,
  input  logic [DATA_W-1:0] operand_c,
  input  logic              condition,
  output prep_t             prep
);

  localparam logic [6:0] WCAP = 7'(MAX_WIDTH);

  logic [6:0]        w, sw, from, wraw, swraw;
  logic [DATA_W-1:0] m, smask, fmask, a, b, c, sa, sb, fa, fb, src, sx;
  logic [DATA_W-1:0] ua, ub;
  logic              na, nb, shift_bad, div0, ovfl;

  always_comb begin
    wraw  = width_of(width_class);
    swraw = width_of(source_class);
    w     = (wraw > WCAP) ? WCAP : wraw;
    sw    = (swraw > WCAP) ? WCAP : swraw;
    m     = mask_of(w);
    a     = operand_a & m;
    b     = operand_b & m;
    c     = operand_c & m;
    sa    = a | ((w < 7'd64 && a[6'(w - 7'd1)]) ? ~m : '0);
    sb    = b | ((w < 7'd64 && b[6'(w - 7'd1)]) ? ~m : '0);
    fa    = sa ^ {1'b1, {(DATA_W-1){1'b0}}};
    fb    = sb ^ {1'b1, {(DATA_W-1){1'b0}}};
    na    = sa[DATA_W-1];
    nb    = sb[DATA_W-1];
    ua    = na ? (DATA_W'(0) - sa) : sa;
    ub    = nb ? (DATA_W'(0) - sb) : sb;

    smask = mask_of(sw);
    src   = operand_a & smask;
    from  = (source_bits >= 7'd1 && source_bits < sw) ? source_bits : sw;
    fmask = mask_of(from);
    sx    = (src & fmask) | ((from < 7'd64 && src[6'(from - 7'd1)]) ? ~fmask : '0);

    shift_bad = (b >= DATA_W'(w));
    div0      = (b == '0);
    ovfl      = (a == (DATA_W'(1) << (w - 7'd1))) && (b == m);

    prep.a         = a;
    prep.b         = b;
    prep.num       = a;
    prep.den       = b;
    prep.side.w    = w;
    prep.side.err  = ERR_NONE;
    prep.side.kind = KIND_SIMPLE;
    prep.side.neg  = 1'b0;
    prep.side.res  = '0;

    unique case (mode)
      OP_ADD:  prep.side.res = a + b;
      OP_SUB:  prep.side.res = a - b;
      OP_MUL:  prep.side.kind = KIND_MUL;
      OP_UDIV, OP_UREM: begin
        prep.side.kind = (mode == OP_UDIV) ? KIND_QUO : KIND_REM;
        if (div0) prep.side.err = ERR_DIV0;
      end
      OP_SDIV, OP_SREM: begin
        prep.num       = ua;
        prep.den       = ub;
        prep.side.kind = (mode == OP_SDIV) ? KIND_QUO : KIND_REM;
        prep.side.neg  = (mode == OP_SDIV) ? (na ^ nb) : na;
        if (div0)      prep.side.err = ERR_DIV0;
        else if (ovfl) prep.side.err = ERR_OVFL;
      end
      OP_SHL, OP_LSHR, OP_ASHR: begin
        if (shift_bad) prep.side.err = ERR_SHIFT;
        else if (mode == OP_SHL)  prep.side.res = a << b[5:0];
        else if (mode == OP_LSHR) prep.side.res = a >> b[5:0];
        else prep.side.res = DATA_W'($signed(sa) >>> b[5:0]);
      end
      OP_AND:  prep.side.res = a & b;
      OP_OR:   prep.side.res = a | b;
      OP_XOR:  prep.side.res = a ^ b;
      OP_SEXT: prep.side.res = sx;
      OP_ZEXT, OP_TRUNC: prep.side.res = src;
      OP_EQ:   prep.side.res = DATA_W'(a == b);
      OP_NE:   prep.side.res = DATA_W'(a != b);
      OP_UGT:  prep.side.res = DATA_W'(a > b);
      OP_UGE:  prep.side.res = DATA_W'(a >= b);
      OP_ULT:  prep.side.res = DATA_W'(a < b);
      OP_ULE:  prep.side.res = DATA_W'(a <= b);
      OP_SGT:  prep.side.res = DATA_W'(fa > fb);
      OP_SGE:  prep.side.res = DATA_W'(fa >= fb);
      OP_SLE:  prep.side.res = DATA_W'(fa <= fb);
      OP_SLT:  prep.side.res = DATA_W'(fa < fb);
      OP_SELECT: prep.side.res = condition ? b : c;
      default: prep.side.res = '0;
    endcase
  end

endmodule

### hdl/mwia_mul.sv
// ----------------------------------------------------------------------------
// mwia_mul - two-stage 64x64 multiplier, low half of the product
// 32x32 partial products in the first stage, sum in the second.
// ----------------------------------------------------------------------------
module mwia_mul import mwia_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] prod
);

  logic [63:0] p_ll;
  logic [31:0] p_lh, p_hl;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= a[31:0] * b[31:0];
      p_lh <= 32'(a[31:0] * b[63:32]);
      p_hl <= 32'(a[63:32] * b[31:0]);
      prod <= p_ll + {p_lh + p_hl, 32'd0};
    end
  end

endmodule

### hdl/mwia_div_step.sv
// ----------------------------------------------------------------------------
// mwia_div_step - one restoring divide step
// Shifts one dividend bit into the partial remainder, subtracts if it fits.
// ----------------------------------------------------------------------------
module mwia_div_step #(
  parameter int DW = 64
) (
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] num_in,
  input  logic [DW-1:0] den,
  output logic [DW-1:0] rem_out,
  output logic [DW-1:0] num_out
);

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          fits;

  always_comb begin
    shifted = {rem_in, num_in[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, den};
    fits    = ~diff[DW+1];
    rem_out = fits ? diff[DW-1:0] : shifted[DW-1:0];
    // quotient bits collect in the vacated low end of the dividend
    num_out = {num_in[DW-2:0], fits};
  end

endmodule

### hdl/multi_width_integer_alu.sv
// ----------------------------------------------------------------------------
// multi_width_integer_alu - pipelined multi-width integer ALU
// One operation per beat at width 1, 8, 16, 32 or 64 bits: add, sub, mul,
// divide/remainder, shifts, logic, casts, compares and select.
// ----------------------------------------------------------------------------
//  channel  dir  tdata bits  fields (low bit up)
//  s_axis   in   216         mode, width_class, source_class, source_bits,
//                            operand_a, operand_b, operand_c, condition
//  m_axis   out  72          value, error_code
//
// Every operation takes the same path through the pipe: one
// decode stage, one restoring divide step per quotient bit, one output stage.
// The divide chain sets the depth; mul runs beside it in two stages.
// One beat per cycle is sustained while m_axis takes results. Every stage advances together whenever the
// output register is empty or being taken, so a stall freezes the whole pipe.
// rst clears the stage valid bits only.
// ----------------------------------------------------------------------------
module multi_width_integer_alu import mwia_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode[4:0] width_class[7:5] source_class[10:8] source_bits[17:11]
  // operand_a[81:18] operand_b[145:82] operand_c[209:146] condition[210]
  input  logic [215:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // value[63:0] error_code[65:64]
  output logic [71:0]  m_tdata
);

  localparam int DW = MAX_WIDTH;

  logic adv;
  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;

  // decode stage
  prep_t prep, p_q;
  logic  v0;

  mwia_prep #(.MAX_WIDTH(MAX_WIDTH)) u_prep (
    .mode        (s_tdata[4:0]),
    .width_class (s_tdata[7:5]),
    .source_class(s_tdata[10:8]),
    .source_bits (s_tdata[17:11]),
    .operand_a   (s_tdata[81:18]),
    .operand_b   (s_tdata[145:82]),
    .operand_c   (s_tdata[209:146]),
    .condition   (s_tdata[210]),
    .prep        (prep)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
    if (adv) p_q <= prep;
  end

  // multiplier lines up with divide stage 2
  logic [DATA_W-1:0] prod;

  mwia_mul u_mul (
    .clk (clk),
    .en  (adv),
    .a   (p_q.a),
    .b   (p_q.b),
    .prod(prod)
  );

  // divide chain; index 0 is the decode register
  side_t         sd  [DW+1];
  logic [DW-1:0] rem [DW+1];
  logic [DW-1:0] num [DW+1];
  logic [DW-1:0] den [DW+1];
  logic          vld [DW+1];

  assign sd[0]  = p_q.side;
  assign rem[0] = '0;
  assign num[0] = p_q.num[DW-1:0];
  assign den[0] = p_q.den[DW-1:0];
  assign vld[0] = v0;

  for (genvar k = 1; k <= DW; k++) begin : g_div
    logic [DW-1:0] rem_next, num_next;
    side_t         sd_next;

    mwia_div_step #(.DW(DW)) u_step (
      .rem_in (rem[k-1]),
      .num_in (num[k-1]),
      .den    (den[k-1]),
      .rem_out(rem_next),
      .num_out(num_next)
    );

    always_comb begin
      sd_next = sd[k-1];
      if (k == 3 && sd[k-1].kind == KIND_MUL) sd_next.res = prod;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vld[k-1];
      end
      if (adv) begin
        sd[k]  <= sd_next;
        rem[k] <= rem_next;
        num[k] <= num_next;
        den[k] <= den[k-1];
      end
    end
  end

  // output stage: sign fix, error squash, width mask
  logic [DATA_W-1:0] dres, fres, value;
  logic [1:0]        error_code;

  always_comb begin
    dres = (sd[DW].kind == KIND_QUO) ? DATA_W'(num[DW]) : DATA_W'(rem[DW]);
    if (sd[DW].neg) dres = DATA_W'(0) - dres;
    fres = (sd[DW].kind == KIND_QUO || sd[DW].kind == KIND_REM) ? dres : sd[DW].res;
    if (sd[DW].err != ERR_NONE) fres = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[DW];
    end
    if (adv) begin
      value      <= fres & mask_of(sd[DW].w);
      error_code <= sd[DW].err;
    end
  end

  assign m_tdata = {6'd0, error_code, value};

  // an accepted beat always lands in the decode register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v0)
    else $error("accepted beat lost at decode stage");

  // any error reports a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && error_code != ERR_NONE) |-> (value == '0))
    else $error("nonzero value with error code");

  // a held result does not move while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(value) && $stable(error_code)))
    else $error("result changed during stall");

endmodule

### test/multi_width_integer_alu_tb.sv
// ----------------------------------------------------------------------------
// multi_width_integer_alu_tb - self-checking bench for the multi-width ALU
// A directed table of operations at every width, then random beats with
// random gaps on both stream sides; every result is checked, in order,
// against a typed-in value or a behavioral model of the ALU.
// ----------------------------------------------------------------------------
module multi_width_integer_alu_tb;
  import mwia_pkg::*;

  localparam int LATENCY     = 66;
  localparam int N_RANDOM    = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        condition;
    logic [63:0] c;
    logic [63:0] b;
    logic [63:0] a;
    logic [6:0]  sbits;
    logic [2:0]  scls;
    logic [2:0]  wcls;
    logic [4:0]  mode;
  } alu_req_t;

  typedef struct packed {
    logic [1:0]  err;
    logic [63:0] value;
  } alu_res_t;

  // directed row: known = 1 when the expected result is typed in
  typedef struct {
    alu_req_t req;
    logic     known;
    alu_res_t res;
  } row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [215:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;

  alu_res_t expected_q[$];
  int       fails;
  int       cycles;
  bit       out_stall_long;

  multi_width_integer_alu u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned bits_of(input logic [2:0] cls);
    case (cls)
      3'd0:    return 1;
      3'd1:    return 8;
      3'd2:    return 16;
      3'd3:    return 32;
      default: return 64;
    endcase
  endfunction

  function automatic logic [63:0] low_mask(input int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input int unsigned w);
    logic [63:0] m;
    m = low_mask(w);
    v &= m;
    if (w < 64 && v[w-1]) v |= ~m;
    return v;
  endfunction

  // behavioral ALU
  function automatic alu_res_t alu_predict(input alu_req_t r);
    int unsigned w, sw, from;
    logic [63:0] m, a, b, c, sa, sb, minv, ua, ub, q, rm, res;
    logic [1:0]  err;
    logic        na, nb;
    w    = bits_of(r.wcls);
    sw   = bits_of(r.scls);
    m    = low_mask(w);
    a    = r.a & m;
    b    = r.b & m;
    c    = r.c & m;
    sa   = sign_ext(a, w);
    sb   = sign_ext(b, w);
    minv = sign_ext(64'd1 << (w - 1), w);
    res  = '0;
    err  = ERR_NONE;
    case (r.mode)
      OP_ADD:   res = a + b;
      OP_SUB:   res = a - b;
      OP_MUL:   res = a * b;
      OP_UDIV, OP_UREM: begin
        if (b == 0) err = ERR_DIV0;
        else res = (r.mode == OP_UDIV) ? a / b : a % b;
      end
      OP_SDIV, OP_SREM: begin
        if (b == 0) err = ERR_DIV0;
        else if (sa == minv && sb == '1) err = ERR_OVFL;
        else begin
          na = sa[63];
          nb = sb[63];
          ua = na ? -sa : sa;
          ub = nb ? -sb : sb;
          q  = ua / ub;
          rm = ua % ub;
          if (r.mode == OP_SDIV) res = (na != nb) ? -q : q;
          else res = na ? -rm : rm;
        end
      end
      OP_SHL, OP_LSHR, OP_ASHR: begin
        if (b >= 64'(w)) err = ERR_SHIFT;
        else if (r.mode == OP_SHL) res = a << b;
        else if (r.mode == OP_LSHR) res = a >> b;
        else res = $signed(sa) >>> b;
      end
      OP_AND:   res = a & b;
      OP_OR:    res = a | b;
      OP_XOR:   res = a ^ b;
      OP_SEXT: begin
        from = sw;
        if (r.sbits >= 7'd1 && 32'(r.sbits) < sw) from = 32'(r.sbits);
        res = sign_ext(r.a & low_mask(sw), from);
      end
      OP_ZEXT, OP_TRUNC: res = r.a & low_mask(sw);
      OP_EQ:    res = {63'd0, a == b};
      OP_NE:    res = {63'd0, a != b};
      OP_UGT:   res = {63'd0, a > b};
      OP_UGE:   res = {63'd0, a >= b};
      OP_ULT:   res = {63'd0, a < b};
      OP_ULE:   res = {63'd0, a <= b};
      OP_SGT:   res = {63'd0, $signed(sa) > $signed(sb)};
      OP_SGE:   res = {63'd0, $signed(sa) >= $signed(sb)};
      OP_SLE:   res = {63'd0, $signed(sa) <= $signed(sb)};
      OP_SLT:   res = {63'd0, $signed(sa) < $signed(sb)};
      OP_SELECT: res = r.condition ? b : c;
      default:  res = '0;
    endcase
    if (err != ERR_NONE) res = '0;
    return '{err: err, value: res & m};
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = SIGN;
      3: v = SIGN - 1;
      4: v = 64'($urandom_range(0, 70));
      default: ;
    endcase
    return v;
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t r;
    r.mode      = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(27, 31)) :
                                                  5'($urandom_range(0, 26));
    r.wcls      = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                                                 3'($urandom_range(0, 4));
    r.scls      = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                                                 3'($urandom_range(0, 4));
    r.sbits     = 7'($urandom_range(0, 127));
    r.a         = rand64();
    r.b         = rand64();
    r.c         = rand64();
    r.condition = 1'($urandom_range(0, 1));
    // divisors of minus one at the width, to hit signed overflow
    if ($urandom_range(0, 7) == 0) begin
      r.b = '1;
      r.a = SIGN >> (64 - bits_of(r.wcls));
    end
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) :
           ($urandom_range(0, 1) ? 0 : $urandom_range(0, 2));
  endfunction

  function automatic alu_req_t mk(input logic [4:0] md, input logic [2:0] wc,
                                  input logic [63:0] a, input logic [63:0] b);
    return '{condition: 1'b0, c: '0, b: b, a: a, sbits: 7'd0, scls: 3'd4,
             wcls: wc, mode: md};
  endfunction

  // send one beat; hold valid until taken
  task automatic send_beat(input alu_req_t r, input logic known, input alu_res_t want);
    s_tvalid <= 1'b1;
    s_tdata  <= 216'(r);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(known ? want : alu_predict(r));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // output side: random backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= out_stall_long ? 1'b0 : ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 200) == 0) out_stall_long <= 1'b1;
      else if (out_stall_long && $urandom_range(0, 20) == 0) out_stall_long <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    alu_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = alu_res_t'(m_tdata[65:0]);
      if (expected_q.size() == 0) begin
        $error("result beat with none expected: value %h err %0d", got.value, got.err);
        fails++;
      end else begin
        want = expected_q.pop_front();
        if (got.value !== want.value) begin
          $error("value: expected %h actual %h", want.value, got.value);
          fails++;
        end
        if (got.err !== want.err) begin
          $error("error_code: expected %0d actual %0d", want.err, got.err);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_width_integer_alu_tb failed");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    alu_req_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    out_stall_long = 1'b0;
    fails = 0;
    cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table: extremes and error codes, most with typed-in results
    rows.push_back('{mk(OP_ADD, 4, '1, 64'd1), 1, '{ERR_NONE, 64'd0}});
    rows.push_back('{mk(OP_SUB, 1, 64'd0, 64'd1), 1, '{ERR_NONE, 64'hff}});
    rows.push_back('{mk(OP_MUL, 4, '1, '1), 1, '{ERR_NONE, 64'd1}});
    rows.push_back('{mk(OP_UDIV, 3, 64'd5, 64'd0), 1, '{ERR_DIV0, 64'd0}});
    rows.push_back('{mk(OP_UREM, 0, 64'd1, 64'd0), 1, '{ERR_DIV0, 64'd0}});
    rows.push_back('{mk(OP_SDIV, 4, SIGN, '1), 1, '{ERR_OVFL, 64'd0}});
    rows.push_back('{mk(OP_SREM, 1, 64'h80, 64'hff), 1, '{ERR_OVFL, 64'd0}});
    rows.push_back('{mk(OP_SDIV, 0, 64'd1, 64'd1), 1, '{ERR_OVFL, 64'd0}});
    rows.push_back('{mk(OP_SHL, 1, 64'd1, 64'd8), 1, '{ERR_SHIFT, 64'd0}});
    rows.push_back('{mk(OP_ASHR, 4, SIGN, 64'd63), 1, '{ERR_NONE, '1}});
    rows.push_back('{mk(OP_LSHR, 0, 64'd1, 64'd1), 1, '{ERR_SHIFT, 64'd0}});
    rows.push_back('{mk(OP_SHL, 2, 64'hffff, 64'd15), 0, '0});
    rows.push_back('{mk(OP_AND, 4, '1, 64'h1234), 0, '0});
    rows.push_back('{mk(OP_OR, 7, 64'd0, '1), 1, '{ERR_NONE, '1}});
    rows.push_back('{mk(OP_XOR, 2, '1, '1), 1, '{ERR_NONE, 64'd0}});
    r = mk(OP_SEXT, 4, 64'h80, 0); r.scls = 1; r.sbits = 0;
    rows.push_back('{r, 1, '{ERR_NONE, 64'hffff_ffff_ffff_ff80}});
    r = mk(OP_SEXT, 4, 64'h08, 0); r.scls = 2; r.sbits = 4;
    rows.push_back('{r, 1, '{ERR_NONE, 64'hffff_ffff_ffff_fff8}});
    r = mk(OP_SEXT, 4, 64'hffff, 0); r.scls = 1; r.sbits = 100;
    rows.push_back('{r, 1, '{ERR_NONE, '1}});
    r = mk(OP_ZEXT, 4, '1, 0); r.scls = 3;
    rows.push_back('{r, 1, '{ERR_NONE, 64'hffff_ffff}});
    r = mk(OP_TRUNC, 1, '1, 0); r.scls = 6;
    rows.push_back('{r, 0, '0});
    rows.push_back('{mk(OP_SLT, 0, 64'd1, 64'd0), 1, '{ERR_NONE, 64'd1}});
    rows.push_back('{mk(OP_SGT, 4, SIGN, SIGN - 1), 1, '{ERR_NONE, 64'd0}});
    rows.push_back('{mk(OP_UGE, 4, '1, 64'd0), 1, '{ERR_NONE, 64'd1}});
    r = mk(OP_SELECT, 4, 0, 64'd7); r.c = 64'd9; r.condition = 1'b0;
    rows.push_back('{r, 1, '{ERR_NONE, 64'd9}});
    rows.push_back('{mk(5'd31, 4, '1, '1), 1, '{ERR_NONE, 64'd0}});

    foreach (rows[i]) send_beat(rows[i].req, rows[i].known, rows[i].res);
    idle_cycles(1);

    for (int i = 0; i < N_RANDOM; i++) begin
      // drain once mid-run so the sender sits idle until the pipe empties
      if (i == N_RANDOM / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end
      send_beat(rand_req(), 1'b0, '0);
      idle_cycles((i > 200 && i < 400) ? 0 : gap_len());
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("multi_width_integer_alu_tb passed");
    end else begin
      $display("multi_width_integer_alu_tb failed");
    end
    $finish;
  end

endmodule
